// File: rtl/sat_pkg.sv
// Shared types and constants for the summed-area table block.
// Used by sat_alu and summed_area_table_rect_sum; depends on nothing.
`default_nettype none

package sat_pkg;

  // Fixed field widths
  localparam int SUM_W   = 28;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Control of the shared accumulate unit
  typedef struct packed {
    logic init;    // load init_value into the accumulator
    logic add_en;  // add or subtract the operand this cycle
    logic sub;     // subtract rather than add
  } alu_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sat_alu.sv
// Shared add/subtract accumulator for table entries and rectangle sums.
// Depends on sat_pkg.
`default_nettype none

module sat_alu (
  input  wire logic                            clk,
  input  wire sat_pkg::alu_ctl_t               ctl,
  input  wire logic signed [sat_pkg::SUM_W-1:0] init_value,
  input  wire logic signed [sat_pkg::SUM_W-1:0] operand,
  output logic signed [sat_pkg::SUM_W-1:0]      acc
);
  import sat_pkg::*;

  logic signed [SUM_W-1:0] acc_next;

  // One add/subtract per cycle, wrapping at the sum width
  always_comb begin
    acc_next = acc;
    if (ctl.init) begin
      acc_next = init_value;
    end else if (ctl.add_en) begin
      acc_next = ctl.sub ? (acc - operand) : (acc + operand);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

`default_nettype wire

// File: rtl/summed_area_table_rect_sum.sv
// Summed-area table builder with rectangle-sum queries: top level.
// Depends on sat_pkg and sat_alu.
//
// Usage:
//   Input channel (in_valid/in_ready): mode 0 loads the next matrix element in
//   raster order and returns its table entry; mode 1 asks for the sum of the
//   inclusive rectangle top_row..bottom_row x left_col..right_col. A query on an
//   incomplete table, with reversed corners or outside the configured size
//   returns query_error = 1 and sum_value = 0.
//   Output channel (out_valid/out_ready): one result item per input item, in
//   order, held in an output register until taken.
//   Config port (cfg_write/cfg_index/cfg_data): row_count and column_count;
//   any write restarts loading at row 0, column 0. Write only while idle.
// Sequence:
//   A load or a valid query passes through an issue state for the first read,
//   four passes of the shared accumulator, each fed by the single registered
//   read port of the table store (a load's last pass takes the left entry
//   from a register instead), and the commit state. A query rejected by the
//   checks goes straight to the commit state. One item at a time; in_ready is
//   high only while the sequencer is idle, so a new item waits until the last one commits.
// Reset: sizes return to their defaults, loading restarts and the table is
//   marked incomplete. The store itself is not cleared.
// Stall: a finished item waits in the commit state while the output register
//   is still full and out_ready is low.
`default_nettype none

module summed_area_table_rect_sum #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sat_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              mode,
  input  wire logic signed [ELEMENT_BITS-1:0]    element,
  input  wire logic [sat_pkg::COORD_W-1:0]       top_row,
  input  wire logic [sat_pkg::COORD_W-1:0]       left_col,
  input  wire logic [sat_pkg::COORD_W-1:0]       bottom_row,
  input  wire logic [sat_pkg::COORD_W-1:0]       right_col,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [sat_pkg::SUM_W-1:0]       sum_value,
  output logic                                   is_query_result,
  output logic                                   query_error
);
  import sat_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [CFG_W-1:0] ROW_RST = CFG_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
  localparam logic [CFG_W-1:0] COL_RST = CFG_W'((MAX_COLS < 64) ? MAX_COLS : 64);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_STEP  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

  state_t state;
  logic [1:0] step;

  // configuration and load position
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [ROW_W-1:0] load_row;
  logic [COL_W-1:0] load_col;
  logic             table_complete;
  logic signed [SUM_W-1:0] left_entry;

  // item registers
  logic             item_query;
  logic             item_err;
  logic [ROW_W-1:0] row_a, row_b;
  logic [COL_W-1:0] col_a, col_b;
  logic [ROW_W-1:0] ld_row;
  logic [COL_W-1:0] ld_col;
  logic [3:0]       step_en;

  // table store
  logic signed [SUM_W-1:0] store [DEPTH];
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [SUM_W-1:0] rd_data;
  logic [1:0]              rd_idx;

  // accumulator
  alu_ctl_t                alu_ctl;
  logic signed [SUM_W-1:0] alu_init;
  logic signed [SUM_W-1:0] alu_operand;
  logic signed [SUM_W-1:0] acc;

  logic             accept;
  logic             commit;
  logic [ROW_W-1:0] r_eff;
  logic [COL_W-1:0] c_eff;
  logic             q_err;
  logic [COORD_W-1:0] top_m1;
  logic [COORD_W-1:0] left_m1;
  logic             row_wrap;
  logic             col_wrap;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == ST_DONE) && (!out_valid || out_ready);

  // A load after completion starts a fresh matrix
  assign r_eff = table_complete ? '0 : load_row;
  assign c_eff = table_complete ? '0 : load_col;

  assign top_m1  = top_row - COORD_W'(1);
  assign left_m1 = left_col - COORD_W'(1);

  // Query checks
  assign q_err = !table_complete || (top_row > bottom_row) || (left_col > right_col) ||
                 ({1'b0, bottom_row} >= row_count) || ({1'b0, right_col} >= column_count);

  // End of row / end of matrix for the item being committed
  assign col_wrap = (32'(ld_col) + 32'd1) >= 32'(column_count);
  assign row_wrap = (32'(ld_row) + 32'd1) >= 32'(row_count);

  // Read address for step k: rows by bit 0, columns by bit 1
  assign rd_idx  = (state == ST_ISSUE) ? 2'd0 : (step + 2'd1);
  assign rd_addr = {rd_idx[0] ? row_b : row_a, rd_idx[1] ? col_b : col_a};

  // Accumulator control: steps 1 and 2 subtract, 0 and 3 add
  always_comb begin
    alu_ctl.init   = accept;
    alu_ctl.add_en = (state == ST_STEP) && step_en[step];
    alu_ctl.sub    = (step == 2'd1) || (step == 2'd2);
    alu_init       = mode ? '0 : SUM_W'(element);
    alu_operand    = (!item_query && (step == 2'd3)) ? left_entry : rd_data;
  end

  sat_alu u_alu (
    .clk        (clk),
    .ctl        (alu_ctl),
    .init_value (alu_init),
    .operand    (alu_operand),
    .acc        (acc)
  );

  // Sequencer, load position and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      out_valid      <= 1'b0;
      row_count      <= ROW_RST;
      column_count   <= COL_RST;
      load_row       <= '0;
      load_col       <= '0;
      table_complete <= 1'b0;
      left_entry     <= '0;
    end else begin
      // output register fills on commit, empties when taken
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (mode && q_err) ? ST_DONE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          step  <= '0;
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (step == 2'd3) begin
            state <= ST_DONE;
          end else begin
            step <= step + 2'd1;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // register write restarts loading; otherwise a committed load advances
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count    <= clamp_count(cfg_data, MAX_ROWS);
          REG_COLUMN_COUNT: column_count <= clamp_count(cfg_data, MAX_COLS);
          default: ;
        endcase
        load_row       <= '0;
        load_col       <= '0;
        table_complete <= 1'b0;
        left_entry     <= '0;
      end else if (commit && !item_query) begin
        left_entry <= acc;
        if (col_wrap) begin
          load_col <= '0;
          if (row_wrap) begin
            load_row       <= '0;
            table_complete <= 1'b1;
          end else begin
            load_row       <= ld_row + ROW_W'(1);
            table_complete <= 1'b0;
          end
        end else begin
          load_col       <= ld_col + COL_W'(1);
          load_row       <= ld_row;
          table_complete <= 1'b0;
        end
      end
    end
  end

  // Item capture: addresses and which terms take part
  always_ff @(posedge clk) begin
    if (accept) begin
      item_query <= mode;
      item_err   <= mode && q_err;
      if (mode) begin
        row_a   <= ROW_W'(bottom_row);
        row_b   <= ROW_W'(top_m1);
        col_a   <= COL_W'(right_col);
        col_b   <= COL_W'(left_m1);
        step_en <= {(top_row != '0) && (left_col != '0), left_col != '0,
                    top_row != '0, 1'b1};
      end else begin
        row_a   <= r_eff - ROW_W'(1);
        row_b   <= r_eff - ROW_W'(1);
        col_a   <= c_eff;
        col_b   <= c_eff - COL_W'(1);
        step_en <= {c_eff != '0, (r_eff != '0) && (c_eff != '0), 1'b0, r_eff != '0};
      end
      ld_row <= r_eff;
      ld_col <= c_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (commit) begin
      sum_value       <= acc;
      is_query_result <= item_query;
      query_error     <= item_err;
    end
  end

  // Table store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && !item_query) begin
      store[{ld_row, ld_col}] <= acc;
    end
    rd_data <= store[rd_addr];
  end

  // Checks
  a_load_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_query_result |-> !query_error)
    else $error("load result flagged as query error");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && query_error |-> sum_value == '0)
    else $error("query error with non-zero sum");

  a_complete_origin: assert property (@(posedge clk) disable iff (rst)
    table_complete |-> (load_row == '0) && (load_col == '0))
    else $error("table complete but load position not at origin");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready again straight after accepting an item");

  a_commit_space: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed item not presented");

endmodule

`default_nettype wire

// File: tb/sv/sat_result_checker.sv
// Result checker for the summed-area table block: follows every accepted item
// and register write, predicts each result item and compares it with the block.
// Depends on sat_pkg.
`default_nettype none

module sat_result_checker #(
  parameter int   MAX_ROWS     = 64,
  parameter int   MAX_COLS     = 64,
  parameter int   ELEMENT_BITS = 16,
  parameter logic QUERY_MODE   = 1'b1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sat_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic                              mode,
  input  wire logic signed [ELEMENT_BITS-1:0]    element,
  input  wire logic [sat_pkg::COORD_W-1:0]       top_row,
  input  wire logic [sat_pkg::COORD_W-1:0]       left_col,
  input  wire logic [sat_pkg::COORD_W-1:0]       bottom_row,
  input  wire logic [sat_pkg::COORD_W-1:0]       right_col,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic signed [sat_pkg::SUM_W-1:0]  sum_value,
  input  wire logic                              is_query_result,
  input  wire logic                              query_error,
  output int                                     mismatches,
  output int                                     pending
);
  import sat_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             is_query;
    logic             err;
  } rect_result_t;

  // Shadow of the table and the load position
  logic [SUM_W-1:0] table_entries [MAX_ROWS][MAX_COLS];
  logic [SUM_W-1:0] row_last;
  int unsigned      next_row, next_col;
  int unsigned      rows_in_use, cols_in_use;
  bit               complete;
  rect_result_t     expected_results [$];

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                             input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void restart_table();
    next_row = 0;
    next_col = 0;
    complete = 1'b0;
    row_last = '0;
  endfunction

  // Next table entry: above + left - upper-left + element, wrapping at SUM_W
  function automatic rect_result_t table_entry(input logic signed [ELEMENT_BITS-1:0] elem);
    rect_result_t     res;
    logic [SUM_W-1:0] acc;
    int unsigned      r, c;
    if (complete) restart_table();
    r = next_row;
    c = next_col;
    acc = {{(SUM_W-ELEMENT_BITS){elem[ELEMENT_BITS-1]}}, elem};
    if (r > 0) acc += table_entries[r-1][c];
    if (c > 0) acc += row_last;
    if (r > 0 && c > 0) acc -= table_entries[r-1][c-1];
    table_entries[r][c] = acc;
    row_last = acc;
    if (c + 1 >= cols_in_use) begin
      next_col = 0;
      if (r + 1 >= rows_in_use) begin
        next_row = 0;
        complete = 1'b1;
      end else begin
        next_row = r + 1;
      end
    end else begin
      next_col = c + 1;
    end
    res.sum = acc;
    res.is_query = 1'b1 ^ 1'b1;
    res.err = 1'b0;
    return res;
  endfunction

  // Rectangle sum by inclusion-exclusion; zero with the error flag when invalid
  function automatic rect_result_t rectangle_sum(input logic [COORD_W-1:0] t, l, b, rc);
    rect_result_t     res;
    logic [SUM_W-1:0] s;
    res.is_query = 1'b1;
    res.err = 1'b0;
    res.sum = '0;
    if (!complete || t > b || l > rc || b >= rows_in_use || rc >= cols_in_use) begin
      res.err = 1'b1;
    end else begin
      s = table_entries[b][rc];
      if (t > 0) s -= table_entries[t-1][rc];
      if (l > 0) s -= table_entries[b][l-1];
      if (t > 0 && l > 0) s += table_entries[t-1][l-1];
      res.sum = s;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    rect_result_t got, want;
    if (rst) begin
      restart_table();
      rows_in_use = clamp_size(7'd64, MAX_ROWS);
      cols_in_use = clamp_size(7'd64, MAX_COLS);
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROW_COUNT) rows_in_use = clamp_size(cfg_data, MAX_ROWS);
        else if (cfg_index == REG_COLUMN_COUNT) cols_in_use = clamp_size(cfg_data, MAX_COLS);
        restart_table();
      end
      if (out_valid && out_ready) begin
        got.sum = sum_value;
        got.is_query = is_query_result;
        got.err = query_error;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result item: sum %0d query %0b error %0b",
                                  $signed(got.sum), got.is_query, got.err));
        end else begin
          want = expected_results.pop_front();
          if (got.sum !== want.sum || got.is_query !== want.is_query ||
              got.err !== want.err)
            note_mismatch($sformatf(
              "result mismatch: expected sum %0d query %0b error %0b, got sum %0d query %0b error %0b",
              $signed(want.sum), want.is_query, want.err,
              $signed(got.sum), got.is_query, got.err));
        end
      end
      if (in_valid && in_ready) begin
        if (mode == QUERY_MODE)
          expected_results.push_back(rectangle_sum(top_row, left_col, bottom_row, right_col));
        else
          expected_results.push_back(table_entry(element));
      end
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench top for the summed-area table block: clock, reset, item stimulus,
// register writes and the verdict. Depends on sat_pkg, the block and sat_result_checker.
`default_nettype none

module tb_top;
  import sat_pkg::*;

  localparam int   MAX_ROWS        = 64;
  localparam int   MAX_COLS        = 64;
  localparam int   ELEMENT_BITS    = 16;
  localparam int   RANDOM_ITEMS    = 1950;
  localparam int   CYCLE_LIMIT     = 400000;
  localparam int   HOLD_OFF_AFTER  = 300;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam logic MODE_LOAD       = 1'b0;
  localparam logic MODE_QUERY      = 1'b1;

  logic                           clk, rst;
  logic                           cfg_write;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]               cfg_data;
  logic                           in_valid, in_ready, mode;
  logic signed [ELEMENT_BITS-1:0] element;
  logic [COORD_W-1:0]             top_row, left_col, bottom_row, right_col;
  logic                           out_valid, out_ready;
  logic signed [SUM_W-1:0]        sum_value;
  logic                           is_query_result, query_error;

  int mismatches, pending;
  int items_sent, results_taken;
  int rows_used, cols_used;
  bit no_idle;

  summed_area_table_rect_sum #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .ELEMENT_BITS(ELEMENT_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .element(element),
    .top_row(top_row), .left_col(left_col), .bottom_row(bottom_row), .right_col(right_col),
    .out_valid(out_valid), .out_ready(out_ready), .sum_value(sum_value),
    .is_query_result(is_query_result), .query_error(query_error)
  );

  sat_result_checker #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .ELEMENT_BITS(ELEMENT_BITS),
    .QUERY_MODE(MODE_QUERY)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .element(element),
    .top_row(top_row), .left_col(left_col), .bottom_row(bottom_row), .right_col(right_col),
    .out_valid(out_valid), .out_ready(out_ready), .sum_value(sum_value),
    .is_query_result(is_query_result), .query_error(query_error),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: random stalls, and one long hold-off while items keep coming
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (!held && results_taken >= HOLD_OFF_AFTER && in_valid === 1'b1) begin
        stall = HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_taken++;
    end
  end

  function automatic int size_in_use(input logic [CFG_W-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic signed [ELEMENT_BITS-1:0] random_element();
    case ($urandom_range(0, 11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return ELEMENT_BITS'($urandom);
    endcase
  endfunction

  // Offer one item after a random gap and wait until it is taken
  task automatic offer_item(input logic m, input logic signed [ELEMENT_BITS-1:0] elem,
                            input logic [COORD_W-1:0] t, l, b, r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    element    <= elem;
    top_row    <= t;
    left_col   <= l;
    bottom_row <= b;
    right_col  <= r;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input logic signed [ELEMENT_BITS-1:0] elem);
    offer_item(MODE_LOAD, elem, COORD_W'($urandom_range(0, 63)),
               COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
               COORD_W'($urandom_range(0, 63)));
  endtask

  task automatic send_query(input logic [COORD_W-1:0] t, l, b, r);
    offer_item(MODE_QUERY, random_element(), t, l, b, r);
  endtask

  // Well-formed rectangle inside the current matrix
  task automatic send_valid_query();
    int t, l, b, r;
    t = $urandom_range(0, rows_used - 1);
    b = $urandom_range(t, rows_used - 1);
    l = $urandom_range(0, cols_used - 1);
    r = $urandom_range(l, cols_used - 1);
    send_query(COORD_W'(t), COORD_W'(l), COORD_W'(b), COORD_W'(r));
  endtask

  // Corners near the matrix edge or anywhere: reversed and out-of-range cases
  task automatic send_odd_query();
    int row_span, col_span;
    if ($urandom_range(0, 1) != 0) begin
      row_span = 63;
      col_span = 63;
    end else begin
      row_span = (rows_used < 64) ? rows_used : 63;
      col_span = (cols_used < 64) ? cols_used : 63;
    end
    send_query(COORD_W'($urandom_range(0, row_span)), COORD_W'($urandom_range(0, col_span)),
               COORD_W'($urandom_range(0, row_span)), COORD_W'($urandom_range(0, col_span)));
  endtask

  task automatic load_matrix(input bit noisy);
    for (int i = 0; i < rows_used * cols_used; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_odd_query();
      send_load(random_element());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes only once the block has gone idle
  task automatic set_sizes(input bit write_rows, input logic [CFG_W-1:0] rows_raw,
                           input bit write_cols, input logic [CFG_W-1:0] cols_raw);
    wait_drained();
    if (write_rows) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_ROW_COUNT;
      cfg_data  <= rows_raw;
      @(posedge clk);
      rows_used = size_in_use(rows_raw, MAX_ROWS);
    end
    if (write_cols) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_COLUMN_COUNT;
      cfg_data  <= cols_raw;
      @(posedge clk);
      cols_used = size_in_use(cols_raw, MAX_COLS);
    end
    cfg_write <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    int phase, pick, total, part, stop_at;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_ROW_COUNT;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    mode       <= MODE_LOAD;
    element    <= '0;
    top_row    <= '0;
    left_col   <= '0;
    bottom_row <= '0;
    right_col  <= '0;
    rows_used = MAX_ROWS;
    cols_used = MAX_COLS;
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: fresh table, a 2x3 matrix of extreme elements, valid queries and every query error case
    send_query(0, 0, 0, 0);
    set_sizes(1'b1, 7'd2, 1'b1, 7'd3);
    send_load(16'sh7FFF);
    send_load(16'sh8000);
    send_load(16'sh7FFF);
    send_query(0, 0, 0, 0);
    send_load('1);
    send_load('0);
    send_load(16'sh8000);
    send_query(0, 0, 1, 2);
    send_query(1, 2, 1, 2);
    send_query(0, 0, 0, 0);
    send_query(1, 0, 0, 2);
    send_query(0, 2, 1, 1);
    send_query(0, 0, 2, 2);
    send_query(0, 0, 1, 3);
    send_query(63, 63, 63, 63);
    // load after a complete matrix starts a new one
    send_load(16'sh0005);
    send_query(0, 0, 0, 0);

    // Random phases: a setting, then a full matrix and queries, or a broken sequence
    stop_at = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case (phase)
        0: set_sizes(1'b1, 7'd0, 1'b1, 7'd127);
        1: set_sizes(1'b1, 7'd64, 1'b1, 7'd0);
        2: set_sizes(1'b1, 7'd1, 1'b1, 7'd1);
        3: set_sizes(1'b1, 7'd100, 1'b1, 7'd2);
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0)
            set_sizes(1'b1, CFG_W'(65 + $urandom_range(0, 62)),
                      1'b1, CFG_W'($urandom_range(0, 3)));
          else if (pick == 1)
            set_sizes(1'b1, CFG_W'($urandom_range(0, 3)),
                      1'b1, CFG_W'(65 + $urandom_range(0, 62)));
          else if (pick < 5)
            set_sizes(pick == 2, CFG_W'($urandom_range(1, 8)),
                      pick != 2, CFG_W'($urandom_range(1, 8)));
          else
            set_sizes(1'b1, CFG_W'($urandom_range(1, 8)), 1'b1, CFG_W'($urandom_range(1, 8)));
        end
      endcase
      phase++;
      total = rows_used * cols_used;

      // broken sequence: partial matrix, then queries on it, then a new setting
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, total - 1)) send_load(random_element());
        repeat ($urandom_range(1, 3)) send_odd_query();
        continue;
      end

      load_matrix($urandom_range(0, 7) == 0);
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(0, 4) == 0) send_odd_query();
        else send_valid_query();
      end

      // reload without a register write, queried part-way through
      if ($urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, total);
        repeat (part) send_load(random_element());
        send_valid_query();
        repeat (total - part) send_load(random_element());
        repeat ($urandom_range(2, 6)) send_valid_query();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/sat_pkg.sv
rtl/sat_alu.sv
rtl/summed_area_table_rect_sum.sv
tb/sv/sat_result_checker.sv
tb/sv/tb_top.sv
